>>> sv/parallel_io_port_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Parallel I/O port controller: assertion macros
// Concurrent checks that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_IO_PORT_CONTROLLER_CORE_ASSERT_SVH
`define PARALLEL_IO_PORT_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define PIOC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define PIOC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PIOC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIOC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> sv/pioc_pkg.sv
// ----------------------------------------------------------------------------
// Parallel I/O port controller package
// Request codes, control byte codes, reset values and small helper functions.
// ----------------------------------------------------------------------------
package pioc_pkg;

    // Request kinds carried in the mode field.
    typedef enum logic [2:0] {
        KIND_WRITE    = 3'd0,
        KIND_READ     = 3'd1,
        KIND_PORT_IN  = 3'd2,
        KIND_INT_ACK  = 3'd3,
        KIND_RETI     = 3'd4,
        KIND_SET_IEI  = 3'd5
    } kind_t;

    // Operating modes held in bits 7..6 of the mode byte.
    typedef enum logic [1:0] {
        MODE_OUTPUT = 2'b00,
        MODE_INPUT  = 2'b01,
        MODE_BIDIR  = 2'b10,
        MODE_BIT    = 2'b11
    } port_mode_t;

    // Low nibble codes of control bytes with bit 0 set.
    localparam logic [3:0] CTRL_INT_CONTROL_TWO = 4'h3;
    localparam logic [3:0] CTRL_INT_CONTROL     = 4'h7;
    localparam logic [3:0] CTRL_MODE            = 4'hF;

    // Bit-mode match selections held in bits 6..5 of the interrupt control.
    localparam logic [1:0] MATCH_ANY_LOW  = 2'b00;
    localparam logic [1:0] MATCH_ANY_HIGH = 2'b01;
    localparam logic [1:0] MATCH_ALL_LOW  = 2'b10;

    // Reset values.
    localparam logic [7:0] PORT_MODE_RESET = 8'h40;
    localparam logic [7:0] DIR_ALL_INPUT   = 8'hFF;
    localparam logic [7:0] DIR_ALL_OUTPUT  = 8'h00;
    localparam logic [7:0] MASK_RESET      = 8'hFF;
    localparam logic [7:0] NO_VECTOR       = 8'hFF;

    // Interrupt chain outputs.
    typedef struct packed {
        logic intr;
        logic oei;
    } chain_t;

    // Pins as seen by a read: input latch where the direction bit is set.
    function automatic logic [7:0] pin_view(input logic [7:0] in_latch,
                                            input logic [7:0] out_latch,
                                            input logic [7:0] dir);
        return (in_latch & dir) | (out_latch & ~dir);
    endfunction

    // Bit-mode match on the unmasked pins; bits 6..5 of the control byte
    // select AND/OR and high/low.
    function automatic logic match_hit(input logic [7:0] ctrl,
                                       input logic [7:0] mask,
                                       input logic [7:0] pins);
        logic [7:0] m;
        logic [7:0] v;
        logic       hit;
        m = ~mask;
        v = pins & m;
        case (ctrl[6:5])
            MATCH_ANY_LOW:  hit = (v != m);
            MATCH_ANY_HIGH: hit = (v != 8'h00);
            MATCH_ALL_LOW:  hit = (v == 8'h00);
            default:        hit = (v == m);
        endcase
        return hit;
    endfunction

    // Daisy chain: channel A first; a channel in service blocks itself and B.
    function automatic chain_t chain_eval(input logic       iei,
                                          input logic [1:0] enb,
                                          input logic [1:0] req,
                                          input logic [1:0] insrv);
        chain_t c;
        c.oei  = iei && (insrv == 2'b00);
        c.intr = 1'b0;
        if (iei && !insrv[0])
        begin
            if (enb[0] && req[0])
                c.intr = 1'b1;
            else if (!insrv[1] && enb[1] && req[1])
                c.intr = 1'b1;
        end
        return c;
    endfunction

endpackage

>>> sv/pioc_cmd_if.sv
// ----------------------------------------------------------------------------
// Parallel I/O port controller request channel
// Valid/ready channel carrying one bus access or pin event.
// ----------------------------------------------------------------------------
interface pioc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [1:0] address;
    logic [7:0] data;
    logic [7:0] bit_mask;
    logic       iei_level;

    modport source (output valid, output mode, output address, output data,
                    output bit_mask, output iei_level, input ready);
    modport sink   (input valid, input mode, input address, input data,
                    input bit_mask, input iei_level, output ready);
endinterface

>>> sv/pioc_rsp_if.sv
// ----------------------------------------------------------------------------
// Parallel I/O port controller result channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface pioc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       port_out_valid;
    logic       port_out_channel;
    logic [7:0] port_out_value;
    logic       intr;
    logic       oei;

    modport source (output valid, output read_data, output port_out_valid,
                    output port_out_channel, output port_out_value,
                    output intr, output oei, input ready);
    modport sink   (input valid, input read_data, input port_out_valid,
                    input port_out_channel, input port_out_value,
                    input intr, input oei, output ready);
endinterface

>>> sv/parallel_io_port_controller_core.sv
// ----------------------------------------------------------------------------
// Parallel I/O port controller core
// Flow: a request waits in the request register, its result in the result register.
// Throughput: one request per cycle while results are taken; the request register
// and the result register form a two-stage pipeline, with state updated on the same edge.
// Reset: asynchronous; both channels return to input mode, the chain enables
// are set and no interrupt is pending.
// ----------------------------------------------------------------------------
`include "parallel_io_port_controller_core_assert.svh"

module parallel_io_port_controller_core (
    input logic        clk,
    input logic        rst_n,
    pioc_cmd_if.sink   cmd,
    pioc_rsp_if.source rsp
);

    // Request register.
    logic       cmd_valid_reg, cmd_valid_next;
    logic [2:0] mode_reg;
    logic [1:0] address_reg;
    logic [7:0] data_reg;
    logic [7:0] bit_mask_reg;
    logic       iei_level_reg;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] read_data_reg, read_data_next;
    logic       pov_reg, pov_next;
    logic       poc_reg, poc_next;
    logic [7:0] poval_reg, poval_next;

    // Channel state.
    logic [7:0] port_mode_reg  [2];
    logic [7:0] port_mode_next [2];
    logic [7:0] int_ctrl_reg   [2];
    logic [7:0] int_ctrl_next  [2];
    logic [7:0] int_ctrl2_reg  [2];
    logic [7:0] int_ctrl2_next [2];
    logic [7:0] dir_reg        [2];
    logic [7:0] dir_next       [2];
    logic [7:0] mask_reg       [2];
    logic [7:0] mask_next      [2];
    logic [7:0] vector_reg     [2];
    logic [7:0] vector_next    [2];
    logic [7:0] out_latch_reg  [2];
    logic [7:0] out_latch_next [2];
    logic [7:0] in_latch_reg   [2];
    logic [7:0] in_latch_next  [2];

    logic [1:0] first_reg, first_next;
    logic [1:0] setdir_reg, setdir_next;
    logic [1:0] setmask_reg, setmask_next;
    logic [1:0] enb_reg, enb_next;
    logic [1:0] req_reg, req_next;
    logic [1:0] insrv_reg, insrv_next;
    logic       iei_reg, iei_next;
    logic       intr_reg, oei_reg;

    logic             out_free;
    logic             fire;
    logic             ch;
    logic [7:0]       d;
    pioc_pkg::chain_t chain_next;

    // Handshake: the request stage moves on whenever the result slot is free.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = !cmd_valid_reg || out_free;
    assign fire      = cmd_valid_reg && out_free;
    assign ch        = address_reg[1];
    assign d         = data_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd.valid && cmd.ready)
            cmd_valid_next = 1'b1;
        else if (fire)
            cmd_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Next state and result for the request held in the request register.
    always_comb
    begin
        port_mode_next = port_mode_reg;
        int_ctrl_next  = int_ctrl_reg;
        int_ctrl2_next = int_ctrl2_reg;
        dir_next       = dir_reg;
        mask_next      = mask_reg;
        vector_next    = vector_reg;
        out_latch_next = out_latch_reg;
        in_latch_next  = in_latch_reg;
        first_next     = first_reg;
        setdir_next    = setdir_reg;
        setmask_next   = setmask_reg;
        enb_next       = enb_reg;
        req_next       = req_reg;
        insrv_next     = insrv_reg;
        iei_next       = iei_reg;
        read_data_next = 8'h00;
        pov_next       = 1'b0;
        poc_next       = 1'b0;
        poval_next     = 8'h00;

        case (pioc_pkg::kind_t'(mode_reg))
            pioc_pkg::KIND_WRITE:
            begin
                if (!address_reg[0])
                begin
                    // Data write: drive the pins when the latch changes or on the channel's first write.
                    if (out_latch_reg[ch] != d || first_reg[ch])
                    begin
                        pov_next          = 1'b1;
                        poc_next          = ch;
                        poval_next        = d;
                        out_latch_next[ch] = d;
                        first_next[ch]    = 1'b0;
                    end
                    if (port_mode_reg[ch][7:6] inside {pioc_pkg::MODE_OUTPUT,
                                                       pioc_pkg::MODE_BIDIR})
                        req_next[ch] = 1'b1;
                    else if (port_mode_reg[ch][7:6] == pioc_pkg::MODE_BIT)
                        req_next[ch] = pioc_pkg::match_hit(int_ctrl_reg[ch], mask_reg[ch],
                            pioc_pkg::pin_view(in_latch_reg[ch], d, dir_reg[ch]));
                end
                else
                begin
                    // Control write: pending operand bytes come first.
                    if (setdir_reg[ch])
                    begin
                        dir_next[ch]    = d;
                        setdir_next[ch] = 1'b0;
                    end
                    else if (setmask_reg[ch])
                    begin
                        mask_next[ch]    = d;
                        setmask_next[ch] = 1'b0;
                    end
                    else if (!d[0])
                        vector_next[ch] = d;
                    else if (d[3:0] == pioc_pkg::CTRL_INT_CONTROL_TWO)
                    begin
                        enb_next[ch]       = d[7];
                        int_ctrl2_next[ch] = d;
                    end
                    else if (d[3:0] == pioc_pkg::CTRL_INT_CONTROL)
                    begin
                        if (d[4])
                        begin
                            if (port_mode_reg[ch][7:6] == pioc_pkg::MODE_BIT)
                                setmask_next[ch] = 1'b1;
                            req_next[ch] = 1'b0;
                        end
                        enb_next[ch]      = d[7];
                        int_ctrl_next[ch] = d;
                    end
                    else if (d[3:0] == pioc_pkg::CTRL_MODE)
                    begin
                        case (pioc_pkg::port_mode_t'(d[7:6]))
                            pioc_pkg::MODE_OUTPUT: dir_next[ch]    = pioc_pkg::DIR_ALL_OUTPUT;
                            pioc_pkg::MODE_INPUT:  dir_next[ch]    = pioc_pkg::DIR_ALL_INPUT;
                            pioc_pkg::MODE_BIT:    setdir_next[ch] = 1'b1;
                            default:               ;
                        endcase
                        port_mode_next[ch] = d;
                    end
                    // A channel in bit mode re-evaluates its match after any control byte.
                    if (port_mode_next[ch][7:6] == pioc_pkg::MODE_BIT)
                        req_next[ch] = pioc_pkg::match_hit(int_ctrl_next[ch], mask_next[ch],
                            pioc_pkg::pin_view(in_latch_reg[ch], out_latch_reg[ch],
                                               dir_next[ch]));
                end
            end

            pioc_pkg::KIND_READ:
            begin
                if (!address_reg[0])
                    read_data_next = pioc_pkg::pin_view(in_latch_reg[ch], out_latch_reg[ch],
                                                        dir_reg[ch]);
                else
                    read_data_next = {port_mode_reg[0][7:6], 2'b00,
                                      port_mode_reg[1][7:6], 2'b00};
            end

            pioc_pkg::KIND_PORT_IN:
            begin
                in_latch_next[ch] = (in_latch_reg[ch] & ~bit_mask_reg) | (d & bit_mask_reg);
                if (port_mode_reg[ch][7:6] inside {pioc_pkg::MODE_INPUT,
                                                   pioc_pkg::MODE_BIDIR})
                    req_next[ch] = 1'b1;
                else if (port_mode_reg[ch][7:6] == pioc_pkg::MODE_BIT)
                    req_next[ch] = pioc_pkg::match_hit(int_ctrl_reg[ch], mask_reg[ch],
                        pioc_pkg::pin_view(in_latch_next[ch], out_latch_reg[ch], dir_reg[ch]));
            end

            pioc_pkg::KIND_INT_ACK:
            begin
                // Serve the highest-priority channel that is not blocked.
                read_data_next = pioc_pkg::NO_VECTOR;
                if (intr_reg && !insrv_reg[0])
                begin
                    if (enb_reg[0] && req_reg[0])
                    begin
                        req_next[0]    = 1'b0;
                        insrv_next[0]  = 1'b1;
                        read_data_next = vector_reg[0];
                    end
                    else if (!insrv_reg[1] && enb_reg[1] && req_reg[1])
                    begin
                        req_next[1]    = 1'b0;
                        insrv_next[1]  = 1'b1;
                        read_data_next = vector_reg[1];
                    end
                end
            end

            pioc_pkg::KIND_RETI:
            begin
                if (insrv_reg[0])
                    insrv_next[0] = 1'b0;
                else if (insrv_reg[1])
                    insrv_next[1] = 1'b0;
            end

            pioc_pkg::KIND_SET_IEI:
                iei_next = iei_level_reg;

            default: ;
        endcase

        chain_next = pioc_pkg::chain_eval(iei_next, enb_next, req_next, insrv_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            mode_reg      <= cmd.mode;
            address_reg   <= cmd.address;
            data_reg      <= cmd.data;
            bit_mask_reg  <= cmd.bit_mask;
            iei_level_reg <= cmd.iei_level;
        end
        if (fire)
        begin
            read_data_reg <= read_data_next;
            pov_reg       <= pov_next;
            poc_reg       <= poc_next;
            poval_reg     <= poval_next;
        end
    end

    // Channel and chain state, updated as each request completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                port_mode_reg[i] <= pioc_pkg::PORT_MODE_RESET;
                int_ctrl_reg[i]  <= 8'h00;
                int_ctrl2_reg[i] <= 8'h00;
                dir_reg[i]       <= pioc_pkg::DIR_ALL_INPUT;
                mask_reg[i]      <= pioc_pkg::MASK_RESET;
                vector_reg[i]    <= 8'h00;
                out_latch_reg[i] <= 8'h00;
                in_latch_reg[i]  <= 8'h00;
            end
            first_reg   <= 2'b11;
            setdir_reg  <= 2'b00;
            setmask_reg <= 2'b00;
            enb_reg     <= 2'b00;
            req_reg     <= 2'b00;
            insrv_reg   <= 2'b00;
            iei_reg     <= 1'b1;
            intr_reg    <= 1'b0;
            oei_reg     <= 1'b1;
        end
        else if (fire)
        begin
            port_mode_reg <= port_mode_next;
            int_ctrl_reg  <= int_ctrl_next;
            int_ctrl2_reg <= int_ctrl2_next;
            dir_reg       <= dir_next;
            mask_reg      <= mask_next;
            vector_reg    <= vector_next;
            out_latch_reg <= out_latch_next;
            in_latch_reg  <= in_latch_next;
            first_reg     <= first_next;
            setdir_reg    <= setdir_next;
            setmask_reg   <= setmask_next;
            enb_reg       <= enb_next;
            req_reg       <= req_next;
            insrv_reg     <= insrv_next;
            iei_reg       <= iei_next;
            intr_reg      <= chain_next.intr;
            oei_reg       <= chain_next.oei;
        end
    end

    // Result port; the chain lines hold while a result waits, as no request completes.
    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = read_data_reg;
    assign rsp.port_out_valid   = pov_reg;
    assign rsp.port_out_channel = poc_reg;
    assign rsp.port_out_value   = poval_reg;
    assign rsp.intr             = intr_reg;
    assign rsp.oei              = oei_reg;

    // Assertions.
    `PIOC_ASSERT(a_intr_needs_iei, clk, rst_n, intr_reg |-> iei_reg, "intr raised without iei")
    `PIOC_ASSERT(a_oei_chain_idle, clk, rst_n, oei_reg |-> (iei_reg && insrv_reg == 2'b00),
                 "oei high while the chain is blocked")
    `PIOC_ASSERT(a_request_held, clk, rst_n, (cmd_valid_reg && !out_free) |=> cmd_valid_reg,
                 "stalled request dropped")
    `PIOC_ASSERT(a_first_sticky, clk, rst_n, !first_reg[0] |=> !first_reg[0],
                 "first-write flag of channel A set again")
    `PIOC_ASSERT_NEVER(a_port_out_idle, clk, rst_n,
                       out_valid_reg && !pov_reg && (poc_reg || poval_reg != 8'h00),
                       "pin drive fields set without a drive")

endmodule

>>> tb/pioc_checker.sv
// ----------------------------------------------------------------------------
// Parallel I/O port controller checker
// Watches the request and result channels. Every accepted request is applied
// to a behavioural copy of both ports and of the interrupt chain, and the
// outcome it gives is queued. Every accepted result is then compared field by
// field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module pioc_checker (
    input  logic clk,
    input  logic rst_n,
    pioc_cmd_if  cmd,
    pioc_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] read_data;
        logic       out_valid;
        logic       out_channel;
        logic [7:0] out_value;
        logic       intr;
        logic       oei;
    } pio_outcome_t;

    // Per-channel registers of the modelled port.
    logic [7:0] mode_byte [2];
    logic [7:0] ictl      [2];
    logic [7:0] ictl_two  [2];
    logic [7:0] dir       [2];
    logic [7:0] imask     [2];
    logic [7:0] ivec      [2];
    logic [7:0] olatch    [2];
    logic [7:0] ilatch    [2];
    logic       first_wr  [2];
    logic       want_dir  [2];
    logic       want_mask [2];
    logic       int_en    [2];
    logic       int_req   [2];
    logic       serving   [2];

    // Shared interrupt chain.
    logic iei_in;
    logic oei_out;
    logic intr_out;

    pio_outcome_t pending_outcomes[$];

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic pioc_pkg::port_mode_t mode_of(input int ch);
        return pioc_pkg::port_mode_t'(mode_byte[ch][7:6]);
    endfunction

    // Input latch where the direction bit is set, output latch elsewhere.
    function automatic logic [7:0] pins(input int ch);
        return (ilatch[ch] & dir[ch]) | (olatch[ch] & ~dir[ch]);
    endfunction

    task automatic clear_ports();
        for (int ch = 0; ch < 2; ch++)
        begin
            mode_byte[ch]  = pioc_pkg::PORT_MODE_RESET;
            ictl[ch]       = 8'h00;
            ictl_two[ch]   = 8'h00;
            dir[ch]        = pioc_pkg::DIR_ALL_INPUT;
            imask[ch]      = pioc_pkg::MASK_RESET;
            ivec[ch]       = 8'h00;
            olatch[ch]     = 8'h00;
            ilatch[ch]     = 8'h00;
            first_wr[ch]   = 1'b1;
            want_dir[ch]   = 1'b0;
            want_mask[ch]  = 1'b0;
            int_en[ch]     = 1'b0;
            int_req[ch]    = 1'b0;
            serving[ch]    = 1'b0;
        end
        iei_in   = 1'b1;
        oei_out  = 1'b1;
        intr_out = 1'b0;
    endtask

    // Channel A ranks first; a channel in service hides itself and channel B.
    task automatic update_chain();
        logic hit;
        hit = 1'b0;
        if (iei_in)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                if (serving[ch])
                    break;
                if (int_en[ch] && int_req[ch])
                begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        intr_out = hit;
        oei_out  = iei_in && !serving[0] && !serving[1];
    endtask

    // Bit mode: request an interrupt when the unmasked pins match.
    task automatic evaluate_match(input int ch);
        logic [7:0] m;
        logic [7:0] v;
        m = ~imask[ch];
        v = pins(ch) & m;
        case (ictl[ch][6:5])
            pioc_pkg::MATCH_ANY_LOW:  int_req[ch] = (v != m);
            pioc_pkg::MATCH_ANY_HIGH: int_req[ch] = (v != 8'h00);
            pioc_pkg::MATCH_ALL_LOW:  int_req[ch] = (v == 8'h00);
            default:                  int_req[ch] = (v == m);
        endcase
    endtask

    // Control byte sequences: a pending direction or mask byte takes
    // precedence, then the vector and the recognised control codes.
    task automatic apply_control(input int ch, input logic [7:0] d);
        if (want_dir[ch])
        begin
            dir[ch]      = d;
            want_dir[ch] = 1'b0;
        end
        else if (want_mask[ch])
        begin
            imask[ch]     = d;
            want_mask[ch] = 1'b0;
        end
        else if (!d[0])
            ivec[ch] = d;
        else if (d[3:0] == pioc_pkg::CTRL_INT_CONTROL_TWO)
        begin
            int_en[ch]   = d[7];
            ictl_two[ch] = d;
        end
        else if (d[3:0] == pioc_pkg::CTRL_INT_CONTROL)
        begin
            if (d[4])
            begin
                if (mode_of(ch) == pioc_pkg::MODE_BIT)
                    want_mask[ch] = 1'b1;
                int_req[ch] = 1'b0;
            end
            int_en[ch] = d[7];
            ictl[ch]   = d;
        end
        else if (d[3:0] == pioc_pkg::CTRL_MODE)
        begin
            case (pioc_pkg::port_mode_t'(d[7:6]))
                pioc_pkg::MODE_OUTPUT: dir[ch] = pioc_pkg::DIR_ALL_OUTPUT;
                pioc_pkg::MODE_INPUT:  dir[ch] = pioc_pkg::DIR_ALL_INPUT;
                pioc_pkg::MODE_BIT:    want_dir[ch] = 1'b1;
                default:               ;
            endcase
            mode_byte[ch] = d;
        end
        if (mode_of(ch) == pioc_pkg::MODE_BIT)
            evaluate_match(ch);
    endtask

    // Applies one request to the modelled port and gives its outcome.
    task automatic predict_pio_step(input logic [2:0] kind, input logic [1:0] addr,
                                    input logic [7:0] d, input logic [7:0] msk,
                                    input logic lvl, output pio_outcome_t res);
        int ch;
        ch  = int'(addr[1]);
        res = '0;
        case (kind)
            pioc_pkg::KIND_WRITE:
            begin
                if (addr[0])
                    apply_control(ch, d);
                else
                begin
                    if (olatch[ch] != d || first_wr[ch])
                    begin
                        res.out_valid   = 1'b1;
                        res.out_channel = ch[0];
                        res.out_value   = d;
                        olatch[ch]      = d;
                        first_wr[ch]    = 1'b0;
                    end
                    if (mode_of(ch) == pioc_pkg::MODE_OUTPUT ||
                        mode_of(ch) == pioc_pkg::MODE_BIDIR)
                        int_req[ch] = 1'b1;
                    else if (mode_of(ch) == pioc_pkg::MODE_BIT)
                        evaluate_match(ch);
                end
            end
            pioc_pkg::KIND_READ:
            begin
                if (addr[0])
                    res.read_data = {mode_byte[0][7:6], 2'b00, mode_byte[1][7:6], 2'b00};
                else
                    res.read_data = pins(ch);
            end
            pioc_pkg::KIND_PORT_IN:
            begin
                ilatch[ch] = (ilatch[ch] & ~msk) | (d & msk);
                if (mode_of(ch) == pioc_pkg::MODE_INPUT ||
                    mode_of(ch) == pioc_pkg::MODE_BIDIR)
                    int_req[ch] = 1'b1;
                else if (mode_of(ch) == pioc_pkg::MODE_BIT)
                    evaluate_match(ch);
            end
            pioc_pkg::KIND_INT_ACK:
            begin
                res.read_data = pioc_pkg::NO_VECTOR;
                if (intr_out)
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        if (serving[c])
                            break;
                        if (int_en[c] && int_req[c])
                        begin
                            int_req[c]    = 1'b0;
                            serving[c]    = 1'b1;
                            res.read_data = ivec[c];
                            break;
                        end
                    end
                end
            end
            pioc_pkg::KIND_RETI:
            begin
                for (int c = 0; c < 2; c++)
                begin
                    if (serving[c])
                    begin
                        serving[c] = 1'b0;
                        break;
                    end
                end
            end
            pioc_pkg::KIND_SET_IEI:
                iei_in = lvl;
            default:
                ;
        endcase
        update_chain();
        res.intr = intr_out;
        res.oei  = oei_out;
    endtask

    task automatic compare_outcome(input pio_outcome_t want);
        if (rsp.read_data !== want.read_data)
            report_error($sformatf("read_data mismatch: got %02h, expected %02h",
                                   rsp.read_data, want.read_data));
        if (rsp.port_out_valid !== want.out_valid)
            report_error($sformatf("port_out_valid mismatch: got %b, expected %b",
                                   rsp.port_out_valid, want.out_valid));
        if (rsp.port_out_channel !== want.out_channel)
            report_error($sformatf("port_out_channel mismatch: got %b, expected %b",
                                   rsp.port_out_channel, want.out_channel));
        if (rsp.port_out_value !== want.out_value)
            report_error($sformatf("port_out_value mismatch: got %02h, expected %02h",
                                   rsp.port_out_value, want.out_value));
        if (rsp.intr !== want.intr)
            report_error($sformatf("intr mismatch: got %b, expected %b",
                                   rsp.intr, want.intr));
        if (rsp.oei !== want.oei)
            report_error($sformatf("oei mismatch: got %b, expected %b",
                                   rsp.oei, want.oei));
    endtask

    // Results are checked before the request of the same edge is queued, as a
    // result can never belong to a request accepted on that same edge.
    always @(posedge clk or negedge rst_n)
    begin
        pio_outcome_t res;
        if (!rst_n)
        begin
            clear_ports();
            pending_outcomes.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_outcomes.size() == 0)
                    report_error("result accepted with no request outstanding");
                else
                    compare_outcome(pending_outcomes.pop_front());
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_pio_step(cmd.mode, cmd.address, cmd.data, cmd.bit_mask,
                                 cmd.iei_level, res);
                pending_outcomes.push_back(res);
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

>>> tb/parallel_io_port_controller_core_tb.sv
// ----------------------------------------------------------------------------
// Parallel I/O port controller testbench
// Drives a short directed sequence over both channels, the interrupt chain and
// the control byte sequences, then random well-formed set-ups mixed with pin
// events, bus accesses and noise, under bursty requests and result stalls.
// ----------------------------------------------------------------------------
module parallel_io_port_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ADDR_A_DATA = 2'd0;
    localparam logic [1:0] ADDR_A_CTRL = 2'd1;
    localparam logic [1:0] ADDR_B_DATA = 2'd2;
    localparam logic [1:0] ADDR_B_CTRL = 2'd3;
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 12;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   burst_left;
    int   sent;
    int   ignored;
    int   hold_at;
    logic hold_now;
    int   hold_left;
    int   phase_left;
    int   stall_style;
    int   mismatches;
    int   in_flight;

    pioc_cmd_if cmd_ch ();
    pioc_rsp_if rsp_ch ();

    parallel_io_port_controller_core dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    pioc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .outstanding(in_flight)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: stall styles that change from phase to phase, plus one
    // long hold-off so that the pipeline fills and the request side stalls.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_now)
        begin
            hold_now = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                phase_left  = $urandom_range(16, 96);
            end
            phase_left--;
            case (stall_style)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= ~rsp_ch.ready;
                default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Offers one request, in bursts of random length with random gaps, and
    // returns on the edge at which it is accepted.
    task automatic send_item(input logic [2:0] kind, input logic [1:0] addr,
                             input logic [7:0] d, input logic [7:0] msk,
                             input logic lvl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.mode      <= kind;
        cmd_ch.address   <= addr;
        cmd_ch.data      <= d;
        cmd_ch.bit_mask  <= msk;
        cmd_ch.iei_level <= lvl;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sent++;
        if (sent == hold_at)
            hold_now = 1'b1;
    endtask

    task automatic write_ctrl(input logic [1:0] addr, input logic [7:0] d);
        send_item(pioc_pkg::KIND_WRITE, addr, d, 8'($urandom), 1'($urandom));
    endtask

    task automatic bare_item(input logic [2:0] kind, input logic [1:0] addr);
        send_item(kind, addr, 8'($urandom), 8'($urandom), 1'b1);
    endtask

    initial
    begin
        int                   ch;
        int                   pick;
        int                   target;
        pioc_pkg::port_mode_t pm;
        logic [1:0]           caddr;
        logic [1:0]           daddr;
        logic                 follow;

        cmd_ch.valid     = 1'b0;
        cmd_ch.mode      = pioc_pkg::KIND_READ;
        cmd_ch.address   = ADDR_A_DATA;
        cmd_ch.data      = 8'h00;
        cmd_ch.bit_mask  = 8'h00;
        cmd_ch.iei_level = 1'b1;
        rsp_ch.ready     = 1'b0;
        hold_now         = 1'b0;
        hold_at          = $urandom_range(300, 800);

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state, first and repeated data writes.
        bare_item(pioc_pkg::KIND_READ, ADDR_A_CTRL);
        bare_item(pioc_pkg::KIND_READ, ADDR_A_DATA);
        send_item(pioc_pkg::KIND_PORT_IN, ADDR_A_DATA, 8'hFF, 8'hFF, 1'b0);
        send_item(pioc_pkg::KIND_PORT_IN, ADDR_B_DATA, 8'h00, 8'h00, 1'b1);
        send_item(pioc_pkg::KIND_WRITE, ADDR_A_DATA, 8'h00, 8'h00, 1'b0);
        send_item(pioc_pkg::KIND_WRITE, ADDR_A_DATA, 8'h00, 8'hFF, 1'b1);
        send_item(pioc_pkg::KIND_WRITE, ADDR_B_DATA, 8'hFF, 8'h00, 1'b0);

        // Channel A as an output with its interrupt enabled, then served.
        write_ctrl(ADDR_A_CTRL, {pioc_pkg::MODE_OUTPUT, 2'b00, pioc_pkg::CTRL_MODE});
        bare_item(pioc_pkg::KIND_READ, ADDR_A_DATA);
        write_ctrl(ADDR_A_CTRL, 8'h10);
        write_ctrl(ADDR_A_CTRL, {1'b1, 2'b00, 1'b0, pioc_pkg::CTRL_INT_CONTROL});
        bare_item(pioc_pkg::KIND_INT_ACK, ADDR_A_DATA);
        bare_item(pioc_pkg::KIND_INT_ACK, ADDR_B_DATA);
        bare_item(pioc_pkg::KIND_RETI, ADDR_A_DATA);

        // Chain enable dropped: acknowledge finds nothing to serve.
        send_item(pioc_pkg::KIND_SET_IEI, ADDR_A_DATA, 8'h00, 8'h00, 1'b0);
        bare_item(pioc_pkg::KIND_INT_ACK, ADDR_A_DATA);
        send_item(pioc_pkg::KIND_SET_IEI, ADDR_A_DATA, 8'hFF, 8'hFF, 1'b1);

        // Channel B in bit mode with a direction, a vector and a mask.
        write_ctrl(ADDR_B_CTRL, {pioc_pkg::MODE_BIT, 2'b00, pioc_pkg::CTRL_MODE});
        write_ctrl(ADDR_B_CTRL, 8'hAA);
        write_ctrl(ADDR_B_CTRL, 8'h22);
        write_ctrl(ADDR_B_CTRL, {1'b1, 2'b11, 1'b1, pioc_pkg::CTRL_INT_CONTROL});
        write_ctrl(ADDR_B_CTRL, 8'h0F);
        send_item(pioc_pkg::KIND_PORT_IN, ADDR_B_DATA, 8'hF0, 8'hFF, 1'b1);
        bare_item(pioc_pkg::KIND_INT_ACK, ADDR_B_DATA);
        bare_item(pioc_pkg::KIND_RETI, ADDR_B_DATA);

        // Second interrupt control, an unrecognised byte, bidirectional mode
        // with the direction left alone, and the unused request codes.
        write_ctrl(ADDR_B_CTRL, {1'b0, 3'b000, pioc_pkg::CTRL_INT_CONTROL_TWO});
        write_ctrl(ADDR_B_CTRL, 8'h05);
        write_ctrl(ADDR_A_CTRL, {pioc_pkg::MODE_BIDIR, 2'b11, pioc_pkg::CTRL_MODE});
        bare_item(KIND_SPARE_LO, ADDR_A_CTRL);
        bare_item(KIND_SPARE_HI, ADDR_B_CTRL);

        target = sent + RANDOM_ITEMS;
        while (sent - ignored < target)
        begin
            ch    = $urandom_range(0, 1);
            caddr = {ch[0], 1'b1};
            daddr = {ch[0], 1'b0};
            pick  = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // Well-formed set-up of one channel.
                pm = pioc_pkg::port_mode_t'($urandom_range(0, 3));
                write_ctrl(caddr, {pm, 2'($urandom), pioc_pkg::CTRL_MODE});
                if (pm == pioc_pkg::MODE_BIT)
                    write_ctrl(caddr, 8'($urandom));
                write_ctrl(caddr, {7'($urandom), 1'b0});
                follow = 1'($urandom);
                write_ctrl(caddr, {($urandom_range(0, 4) != 0), 2'($urandom), follow,
                                   pioc_pkg::CTRL_INT_CONTROL});
                if (follow && pm == pioc_pkg::MODE_BIT)
                    write_ctrl(caddr, 8'($urandom) | 8'($urandom));
            end
            else if (pick < 40)
                send_item(pioc_pkg::KIND_PORT_IN, {ch[0], 1'($urandom)}, 8'($urandom),
                          ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom),
                          1'($urandom));
            else if (pick < 55)
                send_item(pioc_pkg::KIND_WRITE, daddr,
                          $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                          8'($urandom), 1'($urandom));
            else if (pick < 65)
                bare_item(pioc_pkg::KIND_READ, 2'($urandom));
            else if (pick < 77)
                bare_item(pioc_pkg::KIND_INT_ACK, 2'($urandom));
            else if (pick < 85)
                bare_item(pioc_pkg::KIND_RETI, 2'($urandom));
            else if (pick < 89)
                send_item(pioc_pkg::KIND_SET_IEI, 2'($urandom), 8'($urandom), 8'($urandom),
                          ($urandom_range(0, 3) != 0));
            else if (pick < 94)
                write_ctrl(caddr, {7'($urandom), 1'b1});
            else if (pick < 96)
            begin
                bare_item($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI,
                          2'($urandom));
                ignored++;
            end
            else
                send_item(3'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom));
        end
        cmd_ch.valid <= 1'b0;

        // One more edge so that the last accepted request is counted first.
        @(posedge clk);
        wait (in_flight == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
